FILE: rtl/cctr_pkg.sv
package cctr_pkg;

    localparam int IDX_W   = 6;
    localparam int CNT_W   = 32;
    localparam int TOT_W   = 48;
    localparam int ROOT_W  = 17;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 24;

    localparam logic [TOT_W-1:0]  TOTAL_MAX = {TOT_W{1'b1}};
    localparam logic [ROOT_W-1:0] ROOT_ONE  = 17'h10000;

    localparam logic KIND_ACC   = 1'b0;
    localparam logic KIND_XFORM = 1'b1;

    typedef struct packed {
        logic [TOT_W-1:0] r;
        logic [TOT_W-1:0] c;
        logic [TOT_W-1:0] t;
        logic [CNT_W-1:0] v;
    } t_core_req;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              neg;
        logic              zden;
    } t_core_res;

endpackage

FILE: rtl/cctr_core.sv
module cctr_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  cctr_pkg::t_core_req i_req,
    input  logic                i_ack,
    output logic                o_done,
    output cctr_pkg::t_core_res o_res
);
    import cctr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_TV, S_RC, S_CMP, S_NN, S_RA, S_CB, S_DEN,
        S_DSET, S_DIV, S_SQ1, S_SQ2, S_DONE
    } t_state;

    t_state            r_state;
    logic [TOT_W-1:0]  r_r, r_c, r_t;
    logic [CNT_W-1:0]  r_v;
    logic [191:0]      r_acc, r_mcand;
    logic [95:0]       r_mplr;
    logic [6:0]        r_cnt;
    logic [79:0]       r_tv;
    logic [95:0]       r_rc;
    logic [159:0]      r_nn;
    logic [95:0]       r_ra;
    logic [191:0]      r_den;
    logic [191:0]      r_rem;
    logic [63:0]       r_quo;
    logic [63:0]       r_sop;
    logic [34:0]       r_srem;
    logic [31:0]       r_sroot;
    t_core_res         r_res;

    logic [191:0]      acc_sum;
    logic              mul_run, last;
    logic [192:0]      rem2, rem_sub;
    logic              div_ge;
    logic [34:0]       srem_sh, strial;
    logic              sq_ge;
    logic [31:0]       n_root;
    logic [79:0]       n_diff;
    logic [TOT_W-1:0]  t_minus_r, t_minus_c;
    logic              zden_c;

    always_comb begin
        acc_sum   = r_mplr[0] ? r_acc + r_mcand : r_acc;
        mul_run   = r_state inside {S_TV, S_RC, S_NN, S_RA, S_CB, S_DEN};
        last      = (r_cnt == 7'd1);
        rem2      = {r_rem, 1'b0};
        div_ge    = rem2 >= {1'b0, r_den};
        rem_sub   = rem2 - {1'b0, r_den};
        srem_sh   = {r_srem[32:0], r_sop[63:62]};
        strial    = {1'b0, r_sroot, 2'b01};
        sq_ge     = srem_sh >= strial;
        n_root    = {r_sroot[30:0], sq_ge};
        n_diff    = r_tv - r_rc[79:0];
        t_minus_r = r_t - r_r;
        t_minus_c = r_t - r_c;
        zden_c    = (r_r == '0) || (r_c == '0) || (r_t <= r_r) || (r_t <= r_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            if (mul_run) begin
                r_acc   <= acc_sum;
                r_mcand <= r_mcand << 1;
                r_mplr  <= r_mplr >> 1;
                r_cnt   <= r_cnt - 7'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_r     <= i_req.r;
                        r_c     <= i_req.c;
                        r_t     <= i_req.t;
                        r_v     <= i_req.v;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (zden_c) begin
                        r_res   <= '{root: '0, neg: 1'b0, zden: 1'b1};
                        r_state <= S_DONE;
                    end else begin
                        r_acc   <= '0;
                        r_mcand <= 192'(r_t);
                        r_mplr  <= 96'(r_v);
                        r_cnt   <= 7'(CNT_W);
                        r_state <= S_TV;
                    end
                end
                S_TV: begin
                    if (last) begin
                        r_tv    <= acc_sum[79:0];
                        r_acc   <= '0;
                        r_mcand <= 192'(r_r);
                        r_mplr  <= 96'(r_c);
                        r_cnt   <= 7'(TOT_W);
                        r_state <= S_RC;
                    end
                end
                S_RC: begin
                    if (last) begin
                        r_rc    <= acc_sum[95:0];
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (96'(r_tv) < r_rc) begin
                        r_res   <= '{root: '0, neg: 1'b1, zden: 1'b0};
                        r_state <= S_DONE;
                    end else begin
                        r_acc   <= '0;
                        r_mcand <= 192'(n_diff);
                        r_mplr  <= 96'(n_diff);
                        r_cnt   <= 7'd80;
                        r_state <= S_NN;
                    end
                end
                S_NN: begin
                    if (last) begin
                        r_nn    <= acc_sum[159:0];
                        r_acc   <= '0;
                        r_mcand <= 192'(r_r);
                        r_mplr  <= 96'(t_minus_r);
                        r_cnt   <= 7'(TOT_W);
                        r_state <= S_RA;
                    end
                end
                S_RA: begin
                    if (last) begin
                        r_ra    <= acc_sum[95:0];
                        r_acc   <= '0;
                        r_mcand <= 192'(r_c);
                        r_mplr  <= 96'(t_minus_c);
                        r_cnt   <= 7'(TOT_W);
                        r_state <= S_CB;
                    end
                end
                S_CB: begin
                    if (last) begin
                        r_acc   <= '0;
                        r_mcand <= 192'(r_ra);
                        r_mplr  <= acc_sum[95:0];
                        r_cnt   <= 7'd96;
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    if (last) begin
                        r_den   <= acc_sum;
                        r_state <= S_DSET;
                    end
                end
                S_DSET: begin
                    if (192'(r_nn) >= r_den) begin
                        r_res   <= '{root: ROOT_ONE, neg: 1'b0, zden: 1'b0};
                        r_state <= S_DONE;
                    end else begin
                        r_rem   <= 192'(r_nn);
                        r_quo   <= '0;
                        r_cnt   <= 7'd64;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? rem_sub[191:0] : rem2[191:0];
                    r_quo <= {r_quo[62:0], div_ge};
                    r_cnt <= r_cnt - 7'd1;
                    if (last) begin
                        r_sop   <= {r_quo[62:0], div_ge};
                        r_srem  <= '0;
                        r_sroot <= '0;
                        r_cnt   <= 7'd32;
                        r_state <= S_SQ1;
                    end
                end
                S_SQ1, S_SQ2: begin
                    r_sop   <= r_sop << 2;
                    r_srem  <= sq_ge ? srem_sh - strial : srem_sh;
                    r_sroot <= n_root;
                    r_cnt   <= r_cnt - 7'd1;
                    if (last) begin
                        if (r_state == S_SQ1) begin
                            r_sop   <= {32'd0, n_root};
                            r_srem  <= '0;
                            r_sroot <= '0;
                            r_cnt   <= 7'd32;
                            r_state <= S_SQ2;
                        end else begin
                            r_res   <= '{root: {1'b0, n_root[15:0]}, neg: 1'b0, zden: 1'b0};
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (i_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule

FILE: rtl/cooccurrence_correlation_transform.sv
// channel  dir  tdata (low bit up)                         tuser
// s_axis   in   row_index[5:0] col_index[11:6]             kind[0]
//               cell_count[43:12] zero[47:44]
// m_axis   out  root_corr[16:0] was_negative[17]           -
//               zero_denominator[18] total_saturated[19]
//
// accumulate item: total read, then saturating write back
// transform item: computed by the bit-serial shift-add multiplier
//   (352 steps), the 64-step restoring divider and two 32-step square roots
// after reset the row and column totals are cleared first; no item is taken until then
// a finished result waits in the output register; the next item is taken meanwhile
module cooccurrence_correlation_transform #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [cctr_pkg::IN_W-1:0]  s_axis_tdata,   // row_index, col_index, cell_count
    input  logic [0:0]                 s_axis_tuser,   // kind
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [cctr_pkg::OUT_W-1:0] m_axis_tdata    // root_corr, was_negative,
                                                       // zero_denominator, total_saturated
);
    import cctr_pkg::*;

    localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CAW   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int MAXD  = (ROWS > COLS) ? ROWS : COLS;
    localparam int CLR_W = $clog2(MAXD + 1);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_CALC} t_state;

    t_state               r_state;
    logic [CLR_W-1:0]     r_clr;
    logic                 r_kind, r_rin, r_cin;
    logic [RAW-1:0]       r_ra;
    logic [CAW-1:0]       r_ca;
    logic [CNT_W-1:0]     r_v;
    logic [TOT_W-1:0]     r_row_rd, r_col_rd, r_grand;
    logic                 r_sat;
    logic                 r_ovalid;
    t_core_res            r_ores;
    logic                 r_osat;

    logic [TOT_W-1:0]     row_mem [ROWS];
    logic [TOT_W-1:0]     col_mem [COLS];

    logic [IDX_W-1:0]     in_row, in_col;
    logic                 accept, can_load;
    logic [TOT_W:0]       row_sum, col_sum, grand_sum;
    logic                 acc_wr;
    logic                 row_we, col_we;
    logic [RAW-1:0]       row_wa;
    logic [CAW-1:0]       col_wa;
    logic [TOT_W-1:0]     row_wd, col_wd;
    logic                 core_start, core_done;
    t_core_req            core_req;
    t_core_res            core_res;

    assign in_row        = s_axis_tdata[IDX_W-1:0];
    assign in_col        = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign can_load      = !r_ovalid || m_axis_tready;

    always_comb begin
        row_sum   = {1'b0, r_row_rd} + (TOT_W+1)'(r_v);
        col_sum   = {1'b0, r_col_rd} + (TOT_W+1)'(r_v);
        grand_sum = {1'b0, r_grand} + (TOT_W+1)'(r_v);
        acc_wr    = (r_state == ST_READ) && (r_kind == KIND_ACC) && r_rin && r_cin;
        if (r_state == ST_CLEAR) begin
            row_we = (r_clr < CLR_W'(ROWS));
            col_we = (r_clr < CLR_W'(COLS));
            row_wa = r_clr[RAW-1:0];
            col_wa = r_clr[CAW-1:0];
            row_wd = '0;
            col_wd = '0;
        end else begin
            row_we = acc_wr;
            col_we = acc_wr;
            row_wa = r_ra;
            col_wa = r_ca;
            row_wd = row_sum[TOT_W] ? TOTAL_MAX : row_sum[TOT_W-1:0];
            col_wd = col_sum[TOT_W] ? TOTAL_MAX : col_sum[TOT_W-1:0];
        end
        core_start = (r_state == ST_READ) && (r_kind == KIND_XFORM);
        core_req.r = r_rin ? r_row_rd : '0;
        core_req.c = r_cin ? r_col_rd : '0;
        core_req.t = r_grand;
        core_req.v = r_v;
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_wa] <= row_wd;
        end
        if (col_we) begin
            col_mem[col_wa] <= col_wd;
        end
        if (accept) begin
            r_row_rd <= row_mem[RAW'(in_row)];
            r_col_rd <= col_mem[CAW'(in_col)];
        end
    end

    cctr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_req   (core_req),
        .i_ack   ((r_state == ST_CALC) && can_load),
        .o_done  (core_done),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_grand  <= '0;
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + CLR_W'(1);
                    if (r_clr == CLR_W'(MAXD - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_kind  <= s_axis_tuser[0];
                        r_rin   <= (13'(in_row) < 13'(ROWS));
                        r_cin   <= (13'(in_col) < 13'(COLS));
                        r_ra    <= RAW'(in_row);
                        r_ca    <= CAW'(in_col);
                        r_v     <= s_axis_tdata[2*IDX_W+CNT_W-1:2*IDX_W];
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_kind == KIND_ACC) begin
                        if (acc_wr) begin
                            r_grand <= grand_sum[TOT_W] ? TOTAL_MAX : grand_sum[TOT_W-1:0];
                            if (row_sum[TOT_W] || col_sum[TOT_W] || grand_sum[TOT_W]) begin
                                r_sat <= 1'b1;
                            end
                        end
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (core_done && can_load) begin
                        r_ovalid <= 1'b1;
                        r_ores   <= core_res;
                        r_osat   <= r_sat;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_osat, r_ores.zden, r_ores.neg, r_ores.root};

endmodule

FILE: tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cctr_pkg::*;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              neg;
        logic              zden;
        logic              sat;
    } corr_t;

    typedef struct {
        logic              kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [CNT_W-1:0]  cnt;
        bit                typed;
        corr_t             want;
    } stim_t;

    localparam int WATCHDOG = 20000;
    localparam int HOLD_CYCLES = 3000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;   // row_index, col_index, cell_count, zero pad
    logic [0:0]        s_axis_tuser = '0;   // kind
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // root_corr, was_negative, zero_denominator,
                                            // total_saturated, zero pad

    logic [TOT_W-1:0]  row_sum [64];
    logic [TOT_W-1:0]  col_sum [64];
    logic [TOT_W-1:0]  grand_sum = '0;
    logic              sum_clipped = 1'b0;
    corr_t             pending_corr [$];

    int  tx_idle = 0;
    int  rx_idle = 0;
    bit  hold_off = 1'b0;
    bit  failed = 1'b0;
    int  quiet_cycles = 0;

    cooccurrence_correlation_transform dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [TOT_W-1:0] add_clip(input logic [TOT_W-1:0] x,
                                                  input logic [CNT_W-1:0] v);
        logic [TOT_W:0] s;
        s = {1'b0, x} + v;
        if (s > {1'b0, TOTAL_MAX}) begin
            sum_clipped = 1'b1;
            return TOTAL_MAX;
        end
        return s[TOT_W-1:0];
    endfunction

    function automatic corr_t correlate(input logic [TOT_W-1:0] r, input logic [TOT_W-1:0] c,
                                        input logic [TOT_W-1:0] t, input logic [CNT_W-1:0] v);
        corr_t        res;
        logic [319:0] a, b, rhs, den, lhs;
        logic [63:0]  m2;
        longint unsigned lo, hi, mid;
        res = '0;
        res.sat = sum_clipped;
        if (r == 0 || c == 0 || t <= r || t <= c) begin
            res.zden = 1'b1;
            return res;
        end
        a = 320'(t) * 320'(v);
        b = 320'(r) * 320'(c);
        if (a < b) begin
            res.neg = 1'b1;
            return res;
        end
        rhs = ((a - b) * (a - b)) << 64;
        den = 320'(r) * 320'(t - r) * 320'(c) * 320'(t - c);
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            m2 = mid * mid;
            lhs = 320'(m2) * 320'(m2) * den;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        res.root = lo[ROOT_W-1:0];
        return res;
    endfunction

    task automatic send(input logic kind, input logic [IDX_W-1:0] row,
                        input logic [IDX_W-1:0] col, input logic [CNT_W-1:0] cnt,
                        input bit typed = 1'b0, input corr_t want = '0);
        corr_t got;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, cnt, col, row};
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_ACC) begin
            row_sum[row] = add_clip(row_sum[row], cnt);
            col_sum[col] = add_clip(col_sum[col], cnt);
            grand_sum    = add_clip(grand_sum, cnt);
        end else begin
            got = correlate(row_sum[row], col_sum[col], grand_sum, cnt);
            pending_corr.push_back(typed ? want : got);
        end
    endtask

    task automatic random_cells(input int n);
        logic [IDX_W-1:0] r, c;
        logic [CNT_W-1:0] v;
        for (int i = 0; i < n; i++) begin
            r = ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(7));
            c = ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(7));
            case ($urandom_range(9))
                0:       v = '0;
                1:       v = '1;
                2, 3:    v = $urandom;
                default: v = $urandom_range(1000);
            endcase
            send(($urandom_range(99) < 55) ? KIND_ACC : KIND_XFORM, r, c, v);
        end
    endtask

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        corr_t got, exp_c;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.root = m_axis_tdata[ROOT_W-1:0];
            got.neg  = m_axis_tdata[ROOT_W];
            got.zden = m_axis_tdata[ROOT_W+1];
            got.sat  = m_axis_tdata[ROOT_W+2];
            if (pending_corr.size() == 0) begin
                $error("unexpected item %h", got);
                failed = 1'b1;
            end else begin
                exp_c = pending_corr.pop_front();
                if (got.root !== exp_c.root) begin
                    $error("root_corr expected %0d actual %0d", exp_c.root, got.root);
                    failed = 1'b1;
                end
                if (got.neg !== exp_c.neg) begin
                    $error("was_negative expected %0d actual %0d", exp_c.neg, got.neg);
                    failed = 1'b1;
                end
                if (got.zden !== exp_c.zden) begin
                    $error("zero_denominator expected %0d actual %0d", exp_c.zden, got.zden);
                    failed = 1'b1;
                end
                if (got.sat !== exp_c.sat) begin
                    $error("total_saturated expected %0d actual %0d", exp_c.sat, got.sat);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        stim_t cells [$];
        int    drain;
        foreach (row_sum[i]) row_sum[i] = '0;
        foreach (col_sum[i]) col_sum[i] = '0;
        // empty matrix, full-scale cell, rows and columns at the edges
        cells = '{
            '{KIND_XFORM, 6'd0,  6'd0,  32'd0,          1, '{0, 0, 1, 0}},
            '{KIND_ACC,   6'd63, 6'd63, 32'hFFFFFFFF,   0, '0},
            '{KIND_XFORM, 6'd63, 6'd63, 32'd7,          1, '{0, 0, 1, 0}},
            '{KIND_ACC,   6'd0,  6'd1,  32'd100,        0, '0},
            '{KIND_ACC,   6'd1,  6'd0,  32'd100,        0, '0},
            '{KIND_ACC,   6'd1,  6'd1,  32'd0,          0, '0},
            '{KIND_XFORM, 6'd0,  6'd0,  32'd0,          0, '0},
            '{KIND_XFORM, 6'd0,  6'd1,  32'd100,        0, '0},
            '{KIND_XFORM, 6'd1,  6'd0,  32'd0,          0, '0},
            '{KIND_XFORM, 6'd0,  6'd0,  32'hFFFFFFFF,   0, '0},
            '{KIND_XFORM, 6'd5,  6'd5,  32'd1,          1, '{0, 0, 1, 0}},
            '{KIND_XFORM, 6'd63, 6'd0,  32'd3,          0, '0},
            '{KIND_XFORM, 6'd0,  6'd63, 32'd3,          0, '0},
            // row and column totals chosen so that T*v equals r*c
            '{KIND_ACC,   6'd2,  6'd6,  32'd3,          0, '0},
            '{KIND_ACC,   6'd7,  6'd2,  32'd2147483749, 0, '0},
            '{KIND_XFORM, 6'd2,  6'd2,  32'd1,          1, '{0, 0, 0, 0}},
            '{KIND_XFORM, 6'd7,  6'd6,  32'd2,          0, '0}
        };
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle = 24;
        rx_idle = 83;
        foreach (cells[i])
            send(cells[i].kind, cells[i].row, cells[i].col, cells[i].cnt,
                 cells[i].typed, cells[i].want);
        random_cells(130);

        tx_idle = 83;
        rx_idle = 24;
        random_cells(130);

        tx_idle = 0;
        rx_idle = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        random_cells(130);

        send(KIND_XFORM, 6'd0, 6'd0, 32'd5);
        random_cells(20);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_corr.size() == 0);
        drain = 0;
        while (drain < 600) begin
            @(posedge i_clk);
            drain++;
        end
        if (!failed && pending_corr.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
